// ===== hdl/bmp_scanline_pixel_unpack_defines.svh =====
// Assertion macros used by the checker file of the scanline unpacker.
`ifndef BMP_SCANLINE_PIXEL_UNPACK_DEFINES_SVH
`define BMP_SCANLINE_PIXEL_UNPACK_DEFINES_SVH

// same-cycle implication, off during reset
`define BSPU_ASSERT_NOW(label, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bspu assertion failed");

// next-cycle implication, off during reset
`define BSPU_ASSERT_NEXT(label, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bspu assertion failed");

// next-cycle implication that also holds during reset
`define BSPU_ASSERT_ALWAYS(label, ante, cons) \
	label: assert property (@(posedge clk) (ante) |=> (cons)) \
		else $error("bspu assertion failed");

`endif

// ===== hdl/bspu_pkg.sv =====
// Package: constants, codes and shared types of the scanline unpacker.
package bspu_pkg;

	localparam int MAX_WIDTH     = 4096;
	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [2:0] FMT_1BPP  = 3'd0;
	localparam logic [2:0] FMT_2BPP  = 3'd1;
	localparam logic [2:0] FMT_4BPP  = 3'd2;
	localparam logic [2:0] FMT_8BPP  = 3'd3;
	localparam logic [2:0] FMT_24BPP = 3'd4;

	localparam logic REG_FORMAT = 1'b0;
	localparam logic REG_WIDTH  = 1'b1;

	localparam logic MODE_PALETTE = 1'b0;
	localparam logic MODE_PIXEL   = 1'b1;

	typedef struct packed {
		logic [2:0]  fmt;
		logic [12:0] width;
		logic [13:0] width3;
		logic [13:0] row_bytes;
	} cfg_t;

	typedef struct packed {
		logic        en;
		logic [7:0]  addr;
		logic [23:0] rgb;
	} pal_wr_t;

	typedef struct packed {
		logic [7:0]  idx;
		logic        direct;
		logic [23:0] rgb;
		logic        row_end;
		logic        last;
	} px_req_t;

endpackage

// ===== hdl/bspu_cfg.sv =====
// Configuration registers on the APB-style port and derived row geometry.
module bspu_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bspu_pkg::ADDR_W-1:0]   paddr,
	input  logic [bspu_pkg::DATA_W-1:0]   pwdata,
	output logic [bspu_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output bspu_pkg::cfg_t                cfg
);

	logic [2:0]  fmt_q;
	logic [12:0] width_q;
	logic [12:0] w;
	logic [13:0] width3;
	logic [15:0] wbits;
	logic [13:0] nbytes;
	logic [13:0] row_bytes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= bspu_pkg::FMT_8BPP;
			width_q <= 13'd1;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				bspu_pkg::REG_FORMAT: fmt_q   <= pwdata[2:0];
				bspu_pkg::REG_WIDTH:  width_q <= pwdata[12:0];
			endcase
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == bspu_pkg::REG_FORMAT) ? {29'd0, fmt_q} : {19'd0, width_q};

	always_comb begin
		priority if (width_q == 13'd0) begin
			w = 13'd1;
		end else if (17'(width_q) > 17'(bspu_pkg::MAX_WIDTH)) begin
			w = 13'(bspu_pkg::MAX_WIDTH);
		end else begin
			w = width_q;
		end
	end

	always_comb begin
		width3 = 14'({w, 1'b0}) + 14'(w);
		wbits  = 16'(w) << fmt_q[1:0];
		nbytes = 14'((17'(wbits) + 17'd7) >> 3);
		if (fmt_q == bspu_pkg::FMT_24BPP) begin
			row_bytes = (width3 + 14'd3) & ~14'd3;
		end else begin
			row_bytes = (nbytes + 14'd3) & ~14'd3;
		end
	end

	assign cfg.fmt       = fmt_q;
	assign cfg.width     = w;
	assign cfg.width3    = width3;
	assign cfg.row_bytes = row_bytes;

endmodule

// ===== hdl/bspu_unpack.sv =====
// Input register, row position tracking and per-pixel sequencer.
module bspu_unpack (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic               mode,
	input  logic [7:0]         data_byte,
	input  logic [7:0]         entry_index,
	input  logic [7:0]         entry_red,
	input  logic [7:0]         entry_green,
	input  logic [7:0]         entry_blue,
	input  bspu_pkg::cfg_t     cfg,
	output bspu_pkg::pal_wr_t  pal_wr,
	output logic               px_valid,
	input  logic               px_ready,
	output bspu_pkg::px_req_t  px_req
);

	logic        valid_s1;
	logic        mode_s1;
	logic [7:0]  byte_s1;
	logic [7:0]  index_s1;
	logic [23:0] rgb_s1;

	logic [13:0] byte_in_row_q;
	logic [1:0]  phase_q;
	logic [11:0] col3_q;
	logic [15:0] staged_q;

	logic        seq_valid_q;
	logic [7:0]  seq_byte_q;
	logic [3:0]  seq_left_q;
	logic [1:0]  seq_fmt_q;
	logic        seq_hit_q;
	logic        seq_direct_q;
	logic [23:0] seq_rgb_q;

	logic        take;
	logic        step;
	logic        emit;
	logic        is24;
	logic        act24;
	logic        pix24;
	logic        end24;
	logic        pal_act;
	logic        pal_hit;
	logic        wrap;
	logic [16:0] start;
	logic [16:0] diff;
	logic [3:0]  ppb;
	logic [3:0]  cnt;
	logic        issue;
	logic        seq_last;
	logic        seq_free;
	logic [3:0]  seq_bpp;
	logic [7:0]  seq_idx;

	assign issue    = seq_valid_q && px_ready;
	assign seq_last = (seq_left_q == 4'd1);
	assign seq_free = !seq_valid_q || (seq_last && issue);

	assign take       = valid_s1 && seq_free;
	assign item_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			mode_s1  <= mode;
			byte_s1  <= data_byte;
			index_s1 <= entry_index;
			rgb_s1   <= {entry_red, entry_green, entry_blue};
		end
	end

	always_comb begin
		is24    = (cfg.fmt == bspu_pkg::FMT_24BPP);
		step    = take && (mode_s1 == bspu_pkg::MODE_PIXEL) && (cfg.fmt <= bspu_pkg::FMT_24BPP);
		start   = 17'(byte_in_row_q) << (2'd3 - cfg.fmt[1:0]);
		diff    = 17'(cfg.width) - start;
		ppb     = 4'd8 >> cfg.fmt[1:0];
		pal_act = start < 17'(cfg.width);
		pal_hit = diff <= 17'(ppb);
		cnt     = (diff < 17'(ppb)) ? diff[3:0] : ppb;
		act24   = byte_in_row_q < cfg.width3;
		pix24   = act24 && (phase_q == 2'd2);
		end24   = (13'(col3_q) + 13'd1) == cfg.width;
		wrap    = (15'(byte_in_row_q) + 15'd1) >= 15'(cfg.row_bytes);
		emit    = step && (is24 ? pix24 : pal_act);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_in_row_q <= '0;
			phase_q       <= '0;
			col3_q        <= '0;
			staged_q      <= '0;
		end else if (step) begin
			if (is24 && act24 && phase_q == 2'd0) begin
				staged_q[7:0] <= byte_s1;
			end
			if (is24 && act24 && phase_q == 2'd1) begin
				staged_q[15:8] <= byte_s1;
			end
			if (wrap) begin
				byte_in_row_q <= '0;
				phase_q       <= '0;
				col3_q        <= '0;
			end else begin
				byte_in_row_q <= byte_in_row_q + 14'd1;
				if (phase_q == 2'd2) begin
					phase_q <= 2'd0;
					col3_q  <= col3_q + 12'd1;
				end else begin
					phase_q <= phase_q + 2'd1;
				end
			end
		end
	end

	assign seq_bpp = 4'd1 << seq_fmt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_valid_q <= 1'b0;
		end else if (emit) begin
			seq_valid_q <= 1'b1;
		end else if (issue && seq_last) begin
			seq_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			seq_byte_q   <= byte_s1;
			seq_left_q   <= is24 ? 4'd1 : cnt;
			seq_fmt_q    <= cfg.fmt[1:0];
			seq_hit_q    <= is24 ? end24 : pal_hit;
			seq_direct_q <= is24;
			seq_rgb_q    <= {byte_s1, staged_q};
		end else if (issue) begin
			seq_left_q <= seq_left_q - 4'd1;
			seq_byte_q <= seq_byte_q << seq_bpp;
		end
	end

	always_comb begin
		unique case (seq_fmt_q)
			2'd0: seq_idx = {7'd0, seq_byte_q[7]};
			2'd1: seq_idx = {6'd0, seq_byte_q[7:6]};
			2'd2: seq_idx = {4'd0, seq_byte_q[7:4]};
			2'd3: seq_idx = seq_byte_q;
		endcase
	end

	assign px_valid       = seq_valid_q;
	assign px_req.idx     = seq_idx;
	assign px_req.direct  = seq_direct_q;
	assign px_req.rgb     = seq_rgb_q;
	assign px_req.row_end = seq_last && seq_hit_q;
	assign px_req.last    = seq_last;

	assign pal_wr.en   = take && (mode_s1 == bspu_pkg::MODE_PALETTE)
		&& ({1'b0, index_s1} < 9'(bspu_pkg::PALETTE_DEPTH));
	assign pal_wr.addr = index_s1;
	assign pal_wr.rgb  = rgb_s1;

endmodule

// ===== hdl/bspu_pixel_out.sv =====
// Palette memory, lookup stage and output register.
module bspu_pixel_out (
	input  logic               clk,
	input  logic               arst_n,
	input  bspu_pkg::pal_wr_t  pal_wr,
	input  logic               px_valid,
	output logic               px_ready,
	input  bspu_pkg::px_req_t  px_req,
	output logic               pixel_valid,
	input  logic               pixel_ready,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic               row_end,
	output logic               run_last
);

	logic [23:0] mem [bspu_pkg::PALETTE_DEPTH];
	logic [23:0] rdata_q;

	logic        valid_s2;
	logic        direct_s2;
	logic        ok_s2;
	logic [23:0] rgb_s2;
	logic        row_end_s2;
	logic        last_s2;

	logic        valid_s3;
	logic [23:0] rgb_s3;
	logic        row_end_s3;
	logic        last_s3;

	logic        issue;
	logic        s3_free;
	logic [23:0] rgb_sel;

	assign s3_free  = !valid_s3 || pixel_ready;
	assign px_ready = !valid_s2 || s3_free;
	assign issue    = px_valid && px_ready;

	always_ff @(posedge clk) begin
		if (pal_wr.en) begin
			mem[pal_wr.addr[bspu_pkg::PAL_AW-1:0]] <= pal_wr.rgb;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_q <= mem[px_req.idx[bspu_pkg::PAL_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (px_ready) begin
			valid_s2 <= px_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			direct_s2  <= px_req.direct;
			ok_s2      <= {1'b0, px_req.idx} < 9'(bspu_pkg::PALETTE_DEPTH);
			rgb_s2     <= px_req.rgb;
			row_end_s2 <= px_req.row_end;
			last_s2    <= px_req.last;
		end
	end

	always_comb begin
		priority if (direct_s2) begin
			rgb_sel = rgb_s2;
		end else if (ok_s2) begin
			rgb_sel = rdata_q;
		end else begin
			rgb_sel = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && valid_s2) begin
			rgb_s3     <= rgb_sel;
			row_end_s3 <= row_end_s2;
			last_s3    <= last_s2;
		end
	end

	assign pixel_valid = valid_s3;
	assign red         = rgb_s3[23:16];
	assign green       = rgb_s3[15:8];
	assign blue        = rgb_s3[7:0];
	assign row_end     = row_end_s3;
	assign run_last    = last_s3;

endmodule

// ===== hdl/bmp_scanline_pixel_unpack.sv =====
// Top level: BMP scanline byte stream to RGB pixel stream.
// Throughput: one pixel per cycle while pixel_ready holds, fixed by the single palette read
// port; one byte per cycle in 8 and 24 bit formats, while a byte in a sub-byte format is held
// until the last pixel it yields is issued.
// Reset clears pipeline valids and row counters, format to 8 bpp and width to 1;
// palette contents stay undefined until written, with no clearing pass.
module bmp_scanline_pixel_unpack (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bspu_pkg::ADDR_W-1:0]   paddr,
	input  logic [bspu_pkg::DATA_W-1:0]   pwdata,
	output logic [bspu_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic                          mode,
	input  logic [7:0]                    data_byte,
	input  logic [7:0]                    entry_index,
	input  logic [7:0]                    entry_red,
	input  logic [7:0]                    entry_green,
	input  logic [7:0]                    entry_blue,
	output logic                          pixel_valid,
	input  logic                          pixel_ready,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue,
	output logic                          row_end,
	output logic                          run_last
);

	bspu_pkg::cfg_t    cfg;
	bspu_pkg::pal_wr_t pal_wr;
	bspu_pkg::px_req_t px_req;
	logic              px_valid;
	logic              px_ready;

	bspu_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bspu_unpack u_unpack (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.mode        (mode),
		.data_byte   (data_byte),
		.entry_index (entry_index),
		.entry_red   (entry_red),
		.entry_green (entry_green),
		.entry_blue  (entry_blue),
		.cfg         (cfg),
		.pal_wr      (pal_wr),
		.px_valid    (px_valid),
		.px_ready    (px_ready),
		.px_req      (px_req)
	);

	bspu_pixel_out u_pixel_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.pal_wr      (pal_wr),
		.px_valid    (px_valid),
		.px_ready    (px_ready),
		.px_req      (px_req),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.row_end     (row_end),
		.run_last    (run_last)
	);

endmodule

// ===== hdl/bspu_checker.sv =====
// Port-level checker for the scanline unpacker and its bind to the top level.
`include "bmp_scanline_pixel_unpack_defines.svh"

module bspu_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [bspu_pkg::ADDR_W-1:0]   paddr,
	input logic [bspu_pkg::DATA_W-1:0]   pwdata,
	input logic [bspu_pkg::DATA_W-1:0]   prdata,
	input logic                          pixel_valid,
	input logic                          pixel_ready,
	input logic [7:0]                    red,
	input logic [7:0]                    green,
	input logic [7:0]                    blue,
	input logic                          row_end,
	input logic                          run_last
);

	logic cfg_wr;
	logic out_stall;

	assign cfg_wr    = psel && penable && pwrite;
	assign out_stall = pixel_valid && !pixel_ready;

	`BSPU_ASSERT_ALWAYS(a_reset_no_pixel, !arst_n, !pixel_valid)

	`BSPU_ASSERT_NEXT(a_stall_hold, arst_n, out_stall, pixel_valid && $stable({red, green, blue, row_end, run_last}))

	`BSPU_ASSERT_NEXT(a_format_readback, arst_n, cfg_wr && (paddr[2] == bspu_pkg::REG_FORMAT), (paddr[2] != bspu_pkg::REG_FORMAT) || (prdata[2:0] == $past(pwdata[2:0])))

	`BSPU_ASSERT_NEXT(a_width_readback, arst_n, cfg_wr && (paddr[2] == bspu_pkg::REG_WIDTH), (paddr[2] != bspu_pkg::REG_WIDTH) || (prdata[12:0] == $past(pwdata[12:0])))

endmodule

bind bmp_scanline_pixel_unpack bspu_checker u_bspu_checker (.*);
